FILE: rtl/core/c2d_pkg.sv
package c2d_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int MaxKernel = 7;
   localparam int KMaxOdd   = ((MaxKernel - 1) | 1);
   localparam int NumWeights = MaxKernel * MaxKernel;
   localparam int LineW     = MaxWidth + MaxKernel - 1;
   localparam int LineRows  = (MaxKernel > 1) ? MaxKernel - 1 : 1;
   localparam int CntW      = $clog2(LineW + 1);
   localparam int ColW      = $clog2(LineW);
   localparam int RowSelW   = (LineRows > 1) ? $clog2(LineRows) : 1;
   localparam int WIdxW     = $clog2(NumWeights);
   localparam int KW        = $clog2(MaxKernel + 1);
   localparam int SumW      = 40;

   localparam logic [1:0] CsrWidth  = 2'd0;
   localparam logic [1:0] CsrHeight = 2'd1;
   localparam logic [1:0] CsrKernel = 2'd2;

   localparam logic OpLoad  = 1'b0;
   localparam logic OpPixel = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [5:0]  weight_index;
      logic signed [15:0] weight_value;
      logic signed [15:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic signed [SumW-1:0] conv_sum;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_done;
   } rsp_type;

   // classified pixel or weight load passed from front to back
   typedef struct packed {
      logic        is_load;
      logic [WIdxW-1:0] widx;
      logic signed [15:0] wval;
      logic signed [15:0] pix;
      logic [ColW-1:0]  col;
      logic [CntW-1:0]  row;
      logic        emit;
      logic [9:0]  oy;
      logic [9:0]  ox;
      logic        last;
   } cmd_type;

endpackage

FILE: rtl/core/c2d_stream_if.sv
interface c2d_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/conv2d_valid_kxk_unit.sv
// streaming kxk correlation over a pre-padded raster image. write width, height and
// kernel size through csr_ (a write to any of these restarts the frame), load weights
// with opcode 0, then send (w+k-1)*(h+k-1) padded pixels with opcode 1. one beat is
// taken per cycle unless the output stalls; a result leaves a five-stage back pipeline
// (line read, window, multiply, row sums, final sum) behind its pixel. the front counts
// the raster and the back holds the line memories and the 49 parallel multipliers.
module conv2d_valid_kxk_unit (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [10:0] csr_wdata,
   c2d_stream_if.sink req,
   c2d_stream_if.source rsp
);
   import c2d_pkg::*;

   logic q_valid, q_ready;
   cmd_type q_data;
   logic [KW-1:0] k_eff;

   c2d_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data),
      .k_eff(k_eff)
   );

   c2d_back u_back (
      .clock(clock), .reset(reset), .k_eff(k_eff),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

FILE: rtl/core/c2d_front.sv
module c2d_front (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [10:0] csr_wdata,
   input  logic in_valid,
   output logic in_ready,
   input  c2d_pkg::req_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output c2d_pkg::cmd_type out_data,
   output logic [c2d_pkg::KW-1:0] k_eff
);
   import c2d_pkg::*;

   logic [10:0] width_ff, height_ff;
   logic [2:0]  ksize_ff;
   logic [CntW-1:0] row_ff, row_in, col_ff, col_in;
   logic [CntW-1:0] w, h, wp, hp, r, c;
   logic [KW-1:0] k;
   logic [2:0] kodd;
   logic fire;
   cmd_type cmd;

   always_comb begin
      kodd = ksize_ff | 3'd1;
      k = (KW'(kodd) > KW'(KMaxOdd)) ? KW'(KMaxOdd) : KW'(kodd);
      w = (width_ff == 11'd0) ? CntW'(1) :
          (width_ff > 11'(MaxWidth)) ? CntW'(MaxWidth) : CntW'(width_ff);
      h = (height_ff == 11'd0) ? CntW'(1) :
          (height_ff > 11'(MaxHeight)) ? CntW'(MaxHeight) : CntW'(height_ff);
      wp = w + CntW'(k) - CntW'(1);
      hp = h + CntW'(k) - CntW'(1);
      r = row_ff;
      c = col_ff;
      if (r >= hp || c >= wp) begin
         r = '0;
         c = '0;
      end
   end

   assign k_eff = k;
   assign fire = in_valid && in_ready;
   assign in_ready = !out_valid || out_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (fire && in_data.opcode == OpPixel) begin
         if (c + CntW'(1) < wp) begin
            col_in = c + CntW'(1);
            row_in = r;
         end else begin
            col_in = '0;
            row_in = (r + CntW'(1) < hp) ? r + CntW'(1) : '0;
         end
      end
      cmd.is_load = (in_data.opcode == OpLoad);
      cmd.widx = in_data.weight_index;
      cmd.wval = in_data.weight_value;
      cmd.pix = in_data.pixel_value;
      cmd.col = c[ColW-1:0];
      cmd.row = r;
      cmd.emit = (cmd.is_load == 1'b0) && (r + CntW'(1) >= CntW'(k))
                 && (c + CntW'(1) >= CntW'(k));
      cmd.oy = 10'(r + CntW'(1) - CntW'(k));
      cmd.ox = 10'(c + CntW'(1) - CntW'(k));
      cmd.last = (r + CntW'(1) - CntW'(k) == h - CntW'(1))
                 && (c + CntW'(1) - CntW'(k) == w - CntW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd1024;
         height_ff <= 11'd1024;
         ksize_ff <= 3'd3;
         row_ff <= '0;
         col_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrWidth:  width_ff <= csr_wdata;
               CsrHeight: height_ff <= csr_wdata;
               CsrKernel: ksize_ff <= csr_wdata[2:0];
               default: ;
            endcase
            if (csr_index == CsrWidth || csr_index == CsrHeight ||
                csr_index == CsrKernel) begin
               row_ff <= '0;
               col_ff <= '0;
            end
         end else begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (in_ready) out_valid <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) out_data <= cmd;
   end
endmodule

FILE: rtl/core/c2d_back.sv
module c2d_back (
   input  logic clock,
   input  logic reset,
   input  logic [c2d_pkg::KW-1:0] k_eff,
   input  logic in_valid,
   output logic in_ready,
   input  c2d_pkg::cmd_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output c2d_pkg::rsp_type out_data
);
   import c2d_pkg::*;

   localparam int NP = MaxKernel * MaxKernel;
   localparam int PW = 32;
   localparam int S1 = 40;

   logic signed [15:0] wts_ff [NumWeights];
   logic signed [15:0] win_ff [MaxKernel][MaxKernel];
   logic signed [15:0] line_mem [LineRows][LineW];
   logic signed [15:0] rd_ff [LineRows];
   // stage a: command latched while line reads complete
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff;
   cmd_type a_ff, b_ff;
   logic signed [PW-1:0] prod_ff [NP];
   logic signed [S1-1:0] rsum_ff [MaxKernel];
   logic [9:0] c_row_ff, c_col_ff, e_row_ff, e_col_ff;
   logic c_last_ff, e_last_ff;
   rsp_type d_ff;
   logic adv, fire;
   logic signed [15:0] newcol [MaxKernel];
   logic [RowSelW-1:0] wrow;
   logic [KW-1:0] km1;

   // back pipeline stalls as a whole: advance when final slot is free
   assign adv = !d_v_ff || out_ready;
   assign in_ready = adv;
   assign fire = in_valid && in_ready;
   assign out_valid = d_v_ff;
   assign out_data = d_ff;
   assign km1 = k_eff - KW'(1);

   // running row phase avoids any modulo on the row counter
   logic [RowSelW-1:0] ph_ff;
   logic [CntW-1:0] lastrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= '0;
         lastrow_ff <= '0;
      end else if (fire && !in_data.is_load) begin
         lastrow_ff <= in_data.row;
         if (in_data.row == '0) ph_ff <= '0;
         else if (in_data.row != lastrow_ff)
            ph_ff <= (km1 <= KW'(1) || ph_ff + RowSelW'(1) >= RowSelW'(km1)) ?
                     '0 : ph_ff + RowSelW'(1);
      end
   end

   logic [RowSelW-1:0] ph_cur;
   always_comb begin
      ph_cur = ph_ff;
      if (in_data.row == '0) ph_cur = '0;
      else if (in_data.row != lastrow_ff)
         ph_cur = (km1 <= KW'(1) || ph_ff + RowSelW'(1) >= RowSelW'(km1)) ?
                  '0 : ph_ff + RowSelW'(1);
      wrow = ph_cur;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LineRows; i++) begin
         if (fire && !in_data.is_load) begin
            rd_ff[i] <= line_mem[i][in_data.col];
            if (km1 != '0 && RowSelW'(i) == wrow)
               line_mem[i][in_data.col] <= in_data.pix;
         end
      end
   end

   // a load commits as it leaves stage a, so earlier pixels still multiply with old weights
   always_ff @(posedge clock) begin
      if (adv && a_v_ff && a_ff.is_load && int'(a_ff.widx) < NumWeights)
         wts_ff[a_ff.widx] <= a_ff.wval;
   end

   logic [RowSelW-1:0] a_ph_ff;
   always_ff @(posedge clock) begin
      if (fire) begin
         a_ff <= in_data;
         a_ph_ff <= wrow;
      end
   end

   // window shift in stage a
   always_comb begin
      logic [RowSelW-1:0] sel;
      for (int ky = 0; ky < MaxKernel; ky++) begin
         sel = RowSelW'((32'(a_ph_ff) + 32'(ky)) % 32'(1));
         if (km1 != '0) begin
            sel = RowSelW'(32'(a_ph_ff) + 32'(ky));
            if (32'(a_ph_ff) + 32'(ky) >= 32'(km1))
               sel = RowSelW'(32'(a_ph_ff) + 32'(ky) - 32'(km1));
         end
         newcol[ky] = rd_ff[sel];
         if (KW'(ky) == km1) newcol[ky] = a_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int y = 0; y < MaxKernel; y++)
            for (int x = 0; x < MaxKernel; x++) win_ff[y][x] <= '0;
      end else if (adv && a_v_ff && !a_ff.is_load) begin
         for (int y = 0; y < MaxKernel; y++)
            for (int x = 0; x < MaxKernel; x++) begin
               if (KW'(y) < k_eff) begin
                  if (KW'(x) == km1) win_ff[y][x] <= newcol[y];
                  else if (x + 1 < MaxKernel) win_ff[y][x] <= win_ff[y][x+1];
               end
            end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_v_ff) b_ff <= a_ff;
   end

   // multiply stage reads the window just updated
   always_ff @(posedge clock) begin
      if (adv && b_v_ff) begin
         for (int y = 0; y < MaxKernel; y++)
            for (int x = 0; x < MaxKernel; x++) begin
               if (KW'(y) < k_eff && KW'(x) < k_eff)
                  prod_ff[y*MaxKernel+x] <= PW'(win_ff[y][x] *
                     wts_ff[WIdxW'(32'(y) * 32'(k_eff) + 32'(x))]);
               else prod_ff[y*MaxKernel+x] <= '0;
            end
         c_row_ff <= b_ff.oy;
         c_col_ff <= b_ff.ox;
         c_last_ff <= b_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [SumW-1:0] s;
      if (adv && c_v_ff) begin
         for (int y = 0; y < MaxKernel; y++) begin
            s = '0;
            for (int x = 0; x < MaxKernel; x++)
               s = s + SumW'(prod_ff[y*MaxKernel+x]);
            rsum_ff[y] <= s;
         end
         e_row_ff <= c_row_ff;
         e_col_ff <= c_col_ff;
         e_last_ff <= c_last_ff;
      end
   end

   // final sum of row sums lands in the output register
   logic signed [SumW-1:0] tot;
   logic e_v_ff;
   always_comb begin
      tot = '0;
      for (int y = 0; y < MaxKernel; y++) tot = tot + rsum_ff[y];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= fire;
         b_v_ff <= a_v_ff && !a_ff.is_load;
         c_v_ff <= b_v_ff && b_ff.emit;
         e_v_ff <= c_v_ff;
         d_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && e_v_ff) begin
         d_ff.conv_sum <= tot;
         d_ff.out_row <= e_row_ff;
         d_ff.out_col <= e_col_ff;
         d_ff.frame_done <= e_last_ff;
      end
   end
endmodule
